### src/msfa_pkg.sv
`default_nettype none
package msfa_pkg;

  localparam int MAX_STREAMS     = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int TAG_BITS        = 16;

  localparam int STREAM_W        = 3;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int NEED_W          = 4;
  localparam int LIMIT_W         = 3;
  localparam int CFG_W           = 4;
  localparam int IN_FLIGHT_W     = 8;

  localparam int SID_W           = $clog2(MAX_STREAMS);
  localparam int SLOT_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PEND_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W           = $clog2(MAX_STREAMS + 1);
  localparam int TAG_ADDR_W      = SLOT_W + SID_W;
  localparam int TAG_DEPTH       = QUEUE_DEPTH * MAX_STREAMS;

  localparam int CMDQ_DEPTH      = 2;
  localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W      = $clog2(CMDQ_DEPTH + 1);

  localparam int IN_TDATA_W      = ((STREAM_W + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = ((STREAM_W + TAG_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W      = KIND_W;
  localparam int OUT_TUSER_W     = KIND_W + STATUS_W;

  localparam logic [KIND_W-1:0] KIND_XFER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHUT   = 2'd2;

  localparam logic [KIND_W-1:0] RK_STATUS   = 2'd0;
  localparam logic [KIND_W-1:0] RK_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] RK_ABORT    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY       = 2'd3;

  localparam logic CFG_IDX_STREAMS = 1'b0;
  localparam logic CFG_IDX_LIMIT   = 1'b1;

  typedef enum logic [1:0] {
    OP_XFER,
    OP_FINISH,
    OP_SHUT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 sid_bad;
    logic [STREAM_W-1:0]  sid;
    logic [TAG_BITS-1:0]  tag;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_READ,
    S_STATUS
  } state_t;

endpackage
`default_nettype wire

### src/msfa_front.sv
`default_nettype none
module msfa_front (
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [msfa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [msfa_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output msfa_pkg::cmd_t                          q_cmd
);

  logic [msfa_pkg::STREAM_W-1:0] sid;

  assign sid       = in_tdata[msfa_pkg::STREAM_W-1:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.sid     = sid;
    q_cmd.tag     = in_tdata[msfa_pkg::STREAM_W +: msfa_pkg::TAG_BITS];
    q_cmd.sid_bad = (32'(sid) >= msfa_pkg::MAX_STREAMS);
    unique case (in_tuser)
      msfa_pkg::KIND_XFER:   q_cmd.op = msfa_pkg::OP_XFER;
      msfa_pkg::KIND_FINISH: q_cmd.op = msfa_pkg::OP_FINISH;
      msfa_pkg::KIND_SHUT:   q_cmd.op = msfa_pkg::OP_SHUT;
      default:               q_cmd.op = msfa_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

### src/msfa_cmd_fifo.sv
`default_nettype none
module msfa_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire msfa_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output msfa_pkg::cmd_t       head_cmd
);

  msfa_pkg::cmd_t                  entries_r [msfa_pkg::CMDQ_DEPTH];
  logic [msfa_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [msfa_pkg::CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [msfa_pkg::CMDQ_CNT_W-1:0] count_r, count_nxt;

  assign full     = (32'(count_r) == msfa_pkg::CMDQ_DEPTH);
  assign valid    = (count_r != '0);
  assign head_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = msfa_pkg::CMDQ_PTR_W'((32'(wr_ptr_r) + 1) % msfa_pkg::CMDQ_DEPTH);
    end
    if (pop) begin
      rd_ptr_nxt = msfa_pkg::CMDQ_PTR_W'((32'(rd_ptr_r) + 1) % msfa_pkg::CMDQ_DEPTH);
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### src/msfa_back.sv
`default_nettype none
module msfa_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [msfa_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                q_valid,
  input  wire msfa_pkg::cmd_t                      q_cmd,
  output logic                                     q_pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [msfa_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [msfa_pkg::OUT_TUSER_W-1:0]         out_tuser,
  output logic                                     out_tlast
);

  localparam int MS = msfa_pkg::MAX_STREAMS;
  localparam int QD = msfa_pkg::QUEUE_DEPTH;

  msfa_pkg::state_t                   state_r, state_nxt;
  msfa_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic [MS-1:0]                      masks_r [QD];
  logic [MS-1:0]                      masks_nxt [QD];
  logic [msfa_pkg::PEND_W-1:0]        pending_r, pending_nxt;
  logic [msfa_pkg::SLOT_W-1:0]        head_r, head_nxt;
  logic [msfa_pkg::IN_FLIGHT_W-1:0]   in_flight_r, in_flight_nxt;
  logic                               shut_down_r, shut_down_nxt;
  logic [msfa_pkg::NEED_W-1:0]        need_cfg_r;
  logic [msfa_pkg::LIMIT_W-1:0]       limit_cfg_r;

  logic [MS-1:0]                      scan_mask_r, scan_mask_nxt;
  logic [msfa_pkg::SLOT_W-1:0]        scan_slot_r, scan_slot_nxt;
  logic [msfa_pkg::PEND_W-1:0]        frames_left_r, frames_left_nxt;
  logic                               scan_abort_r, scan_abort_nxt;
  logic [msfa_pkg::SID_W-1:0]         scan_sid_r, scan_sid_nxt;
  logic [msfa_pkg::STATUS_W-1:0]      status_r, status_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [msfa_pkg::KIND_W-1:0]        out_kind_r, out_kind_nxt;
  logic [msfa_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [msfa_pkg::STREAM_W-1:0]      out_stream_r, out_stream_nxt;
  logic [msfa_pkg::TAG_BITS-1:0]      out_tag_r, out_tag_nxt;
  logic                               out_last_r, out_last_nxt;

  logic [msfa_pkg::TAG_BITS-1:0]      tag_mem [msfa_pkg::TAG_DEPTH];
  logic [msfa_pkg::TAG_BITS-1:0]      rd_data_r;
  logic                               mem_we, mem_re;
  logic [msfa_pkg::TAG_ADDR_W-1:0]    mem_waddr, mem_raddr;

  logic [msfa_pkg::CNT_W-1:0]         need;
  logic [msfa_pkg::PEND_W-1:0]        limit;
  logic                               out_free;
  logic [msfa_pkg::SID_W-1:0]         sid;
  logic                               found;
  logic                               open_new;
  logic [msfa_pkg::SLOT_W-1:0]        slot_sel;
  logic [msfa_pkg::SLOT_W-1:0]        slot_i;
  logic [MS-1:0]                      slot_mask_new;
  logic [MS-1:0]                      head_mask_new;
  logic [msfa_pkg::CNT_W-1:0]         head_cnt;
  logic                               complete;
  logic [msfa_pkg::SID_W-1:0]         low_sid;
  logic [msfa_pkg::SLOT_W-1:0]        next_slot;

  assign out_free = !out_valid_r || out_tready;
  assign sid      = cmd_r.sid[msfa_pkg::SID_W-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_status_r, out_kind_r};
  assign out_tdata  = {{(msfa_pkg::OUT_TDATA_W - msfa_pkg::STREAM_W - msfa_pkg::TAG_BITS){1'b0}},
                       out_tag_r, out_stream_r};

  // clamp the configuration to the supported range
  always_comb begin
    if (need_cfg_r == '0) begin
      need = msfa_pkg::CNT_W'(1);
    end else if (32'(need_cfg_r) > MS) begin
      need = msfa_pkg::CNT_W'(MS);
    end else begin
      need = msfa_pkg::CNT_W'(need_cfg_r);
    end
    if (32'(limit_cfg_r) > QD) begin
      limit = msfa_pkg::PEND_W'(QD);
    end else begin
      limit = msfa_pkg::PEND_W'(limit_cfg_r);
    end
  end

  // oldest pending frame missing this stream, else a new slot; also whether the head frame completes
  always_comb begin
    found    = 1'b0;
    slot_sel = msfa_pkg::SLOT_W'((32'(head_r) + 32'(pending_r)) % QD);
    for (int i = 0; i < QD; i++) begin
      slot_i = msfa_pkg::SLOT_W'((32'(head_r) + i) % QD);
      if (!found && (i < 32'(pending_r)) && !masks_r[slot_i][sid]) begin
        found    = 1'b1;
        slot_sel = slot_i;
      end
    end
    slot_i   = '0;
    open_new = !found && (pending_r < limit);
    slot_mask_new = (open_new ? '0 : masks_r[slot_sel]) | (MS'(1) << sid);
    head_mask_new = (slot_sel == head_r) ? slot_mask_new : masks_r[head_r];
    head_cnt = '0;
    for (int s = 0; s < MS; s++) begin
      head_cnt = head_cnt + msfa_pkg::CNT_W'(head_mask_new[s]);
    end
    complete = (head_cnt >= need);
  end

  always_comb begin
    low_sid = '0;
    for (int s = MS - 1; s >= 0; s--) begin
      if (scan_mask_r[s]) begin
        low_sid = msfa_pkg::SID_W'(s);
      end
    end
    next_slot = msfa_pkg::SLOT_W'((32'(scan_slot_r) + 1) % QD);
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    masks_nxt       = masks_r;
    pending_nxt     = pending_r;
    head_nxt        = head_r;
    in_flight_nxt   = in_flight_r;
    shut_down_nxt   = shut_down_r;
    scan_mask_nxt   = scan_mask_r;
    scan_slot_nxt   = scan_slot_r;
    frames_left_nxt = frames_left_r;
    scan_abort_nxt  = scan_abort_r;
    scan_sid_nxt    = scan_sid_r;
    status_nxt      = status_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = {slot_sel, sid};
    mem_re          = 1'b0;
    mem_raddr       = {scan_slot_r, low_sid};
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_stream_nxt  = out_stream_r;
    out_tag_nxt     = out_tag_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      msfa_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = msfa_pkg::S_EXEC;
        end
      end

      msfa_pkg::S_EXEC: begin
        status_nxt = msfa_pkg::ST_OK;
        state_nxt  = msfa_pkg::S_STATUS;
        unique case (cmd_r.op)
          msfa_pkg::OP_XFER: begin
            if (shut_down_r) begin
              status_nxt = msfa_pkg::ST_NOT_ACTIVE;
            end else if (cmd_r.sid_bad || (!found && !open_new)) begin
              status_nxt = msfa_pkg::ST_FULL;
            end else begin
              mem_we              = 1'b1;
              masks_nxt[slot_sel] = slot_mask_new;
              pending_nxt         = pending_r + msfa_pkg::PEND_W'(open_new);
              if (complete) begin
                masks_nxt[head_r] = '0;
                pending_nxt       = pending_r + msfa_pkg::PEND_W'(open_new) - 1'b1;
                head_nxt          = msfa_pkg::SLOT_W'((32'(head_r) + 1) % QD);
                if (in_flight_r != '1) begin
                  in_flight_nxt = in_flight_r + 1'b1;
                end
                scan_mask_nxt   = head_mask_new;
                scan_slot_nxt   = head_r;
                frames_left_nxt = msfa_pkg::PEND_W'(1);
                scan_abort_nxt  = 1'b0;
                state_nxt       = msfa_pkg::S_SCAN;
              end
            end
          end
          msfa_pkg::OP_FINISH: begin
            if (in_flight_r != '0) begin
              in_flight_nxt = in_flight_r - 1'b1;
            end
          end
          msfa_pkg::OP_SHUT: begin
            shut_down_nxt = 1'b1;
            if (in_flight_r != '0) begin
              status_nxt = msfa_pkg::ST_BUSY;
            end else if (pending_r == '0) begin
              for (int q = 0; q < QD; q++) begin
                masks_nxt[q] = '0;
              end
              head_nxt = '0;
            end else begin
              scan_mask_nxt   = masks_r[head_r];
              scan_slot_nxt   = head_r;
              frames_left_nxt = pending_r;
              scan_abort_nxt  = 1'b1;
              state_nxt       = msfa_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      msfa_pkg::S_SCAN: begin
        if (scan_mask_r != '0) begin
          mem_re                 = 1'b1;
          scan_sid_nxt           = low_sid;
          scan_mask_nxt[low_sid] = 1'b0;
          state_nxt              = msfa_pkg::S_READ;
        end else if (frames_left_r > msfa_pkg::PEND_W'(1)) begin
          scan_slot_nxt   = next_slot;
          scan_mask_nxt   = masks_r[next_slot];
          frames_left_nxt = frames_left_r - 1'b1;
        end else begin
          if (scan_abort_r) begin
            for (int q = 0; q < QD; q++) begin
              masks_nxt[q] = '0;
            end
            pending_nxt = '0;
            head_nxt    = '0;
          end
          state_nxt = msfa_pkg::S_STATUS;
        end
      end

      msfa_pkg::S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = scan_abort_r ? msfa_pkg::RK_ABORT : msfa_pkg::RK_DISPATCH;
          out_status_nxt = msfa_pkg::ST_OK;
          out_stream_nxt = msfa_pkg::STREAM_W'(scan_sid_r);
          out_tag_nxt    = rd_data_r;
          out_last_nxt   = 1'b0;
          state_nxt      = msfa_pkg::S_SCAN;
        end
      end

      msfa_pkg::S_STATUS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = msfa_pkg::RK_STATUS;
          out_status_nxt = status_r;
          out_stream_nxt = '0;
          out_tag_nxt    = '0;
          out_last_nxt   = 1'b1;
          if (q_valid) begin
            q_pop     = 1'b1;
            cmd_nxt   = q_cmd;
            state_nxt = msfa_pkg::S_EXEC;
          end else begin
            state_nxt = msfa_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = msfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msfa_pkg::S_IDLE;
      pending_r   <= '0;
      head_r      <= '0;
      in_flight_r <= '0;
      shut_down_r <= 1'b0;
      out_valid_r <= 1'b0;
      need_cfg_r  <= msfa_pkg::NEED_W'(8);
      limit_cfg_r <= msfa_pkg::LIMIT_W'(4);
      for (int q = 0; q < QD; q++) begin
        masks_r[q] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      head_r      <= head_nxt;
      in_flight_r <= in_flight_nxt;
      shut_down_r <= shut_down_nxt;
      out_valid_r <= out_valid_nxt;
      masks_r     <= masks_nxt;
      if (cfg_we && (cfg_index == msfa_pkg::CFG_IDX_STREAMS)) begin
        need_cfg_r <= msfa_pkg::NEED_W'(cfg_wdata);
      end
      if (cfg_we && (cfg_index == msfa_pkg::CFG_IDX_LIMIT)) begin
        limit_cfg_r <= msfa_pkg::LIMIT_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    scan_mask_r   <= scan_mask_nxt;
    scan_slot_r   <= scan_slot_nxt;
    frames_left_r <= frames_left_nxt;
    scan_abort_r  <= scan_abort_nxt;
    scan_sid_r    <= scan_sid_nxt;
    status_r      <= status_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_stream_r  <= out_stream_nxt;
    out_tag_r     <= out_tag_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= cmd_r.tag;
    end
    if (mem_re) begin
      rd_data_r <= tag_mem[mem_raddr];
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pending_r) <= QD)
    else $error("pending frame count above queue depth");

  a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  a_shutdown_sticky: assert property (@(posedge clk)
    rst_n && shut_down_r |=> shut_down_r)
    else $error("shutdown flag cleared without reset");

  a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msfa_pkg::S_READ) && $past(state_r == msfa_pkg::S_SCAN) |-> $past(mem_re))
    else $error("tag read state entered without a memory read");

endmodule
`default_nettype wire

### src/multi_stream_frame_accumulator_core.sv
`default_nettype none
// channel   | direction | handshake          | payload
// in_       | input     | in_tvalid/tready   | tuser kind, tdata stream_id + tag
// out_      | output    | out_tvalid/tready  | tuser result_kind + status, tdata
//           |           |                    | out_stream + out_tag, tlast last
// cfg_      | input     | cfg_we             | cfg_index, cfg_wdata
//
// an item with no dispatch or abort passes through the execute and status states
// each dispatched or aborted tag adds a scan and a read state: one tag memory read port, registered
// reset is synchronous; tag memory needs no clearing pass
// a 2-entry command queue takes items while the back end works or the output stalls
module multi_stream_frame_accumulator_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [msfa_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [msfa_pkg::IN_TDATA_W-1:0]     in_tdata,   // stream_id, tag
  input  wire logic [msfa_pkg::IN_TUSER_W-1:0]     in_tuser,   // kind
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [msfa_pkg::OUT_TDATA_W-1:0]         out_tdata,  // out_stream, out_tag
  output logic [msfa_pkg::OUT_TUSER_W-1:0]         out_tuser,  // result_kind, status
  output logic                                     out_tlast
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  msfa_pkg::cmd_t  push_cmd;
  msfa_pkg::cmd_t  head_cmd;

  msfa_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  msfa_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  msfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
